[rtl/hbad_pkg.sv]
// Shared types, codes and character tables for the hex / base64 asset decoder.
// Used by every module of the decoder; depends on nothing else.
package hbad_pkg;

  localparam int unsigned CountWidth = 17;
  localparam logic [CountWidth-1:0] MAX_CAPACITY = 17'd65536;
  localparam logic [CountWidth-1:0] CAPACITY_RESET = 17'd4096;

  // Input operation codes.
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CHAR   = 2'd1;
  localparam logic [1:0] OP_EOL    = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_EOL    = 2'd1;
  localparam logic [1:0] KIND_FINAL  = 2'd2;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [5:0] B64_PLUS_VALUE  = 6'd62;
  localparam logic [5:0] B64_SLASH_VALUE = 6'd63;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } digit_t;

  // One queue entry: all results caused by one input item.
  typedef struct packed {
    logic [1:0]            nres;     // number of results, 1 to 3
    logic [1:0]            kind;     // KIND_DATA for byte results
    logic [2:0][7:0]       bytes;    // bytes[0] goes out first
    logic [CountWidth-1:0] base;     // count carried by the first result
    logic                  error;
    logic                  success;
  } packet_t;

  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t d;
    d.ok = 1'b1;
    d.value = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = 6'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.value = 6'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.value = 6'(c - 8'h41 + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic digit_t b64_digit(input logic [7:0] c);
    digit_t d;
    d.ok = 1'b1;
    d.value = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      d.value = B64_PLUS_VALUE;
    end else if (c == CHAR_SLASH) begin
      d.value = B64_SLASH_VALUE;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

[rtl/hbad_front.sv]
// Front end: accepts items, keeps the line and count state, and builds at most
// one result packet per item. Depends on hbad_pkg.
module hbad_front import hbad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            operation,
  input  logic [7:0]            character,
  input  logic                  base64_mode,
  input  logic                  cfg_valid,
  input  logic [CountWidth-1:0] cfg_data,
  input  logic                  queue_full,
  output logic                  push,
  output packet_t               push_packet
);

  logic [CountWidth-1:0] capacity;
  logic [17:0]           sextet_hold, sextet_hold_next;
  logic [1:0]            group_position, group_position_next;
  logic                  line_char_seen, line_char_seen_next;
  logic [1:0]            padding_seen, padding_seen_next;
  logic [CountWidth-1:0] decoded_count, decoded_count_next;
  logic                  error_latched, error_latched_next;

  logic                  accept;
  logic [1:0]            emit_k;
  logic [2:0][7:0]       emit_bytes;
  logic [CountWidth-1:0] limit;
  logic [CountWidth-1:0] room;
  logic [1:0]            emitted;
  logic                  b64_err;
  logic [5:0]            b64_value;
  logic [1:0]            pad_after;
  logic [23:0]           full_group;
  logic                  line_error;
  digit_t                hd;
  digit_t                bd;
  packet_t               pkt;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign limit    = (capacity < MAX_CAPACITY) ? capacity : MAX_CAPACITY;
  assign hd       = hex_digit(character);
  assign bd       = b64_digit(character);

  // Error check at the end of a line: open pair or group, or empty base64 line.
  assign line_error = (group_position != 2'd0) || (base64_mode && !line_char_seen);

  always_comb begin
    sextet_hold_next    = sextet_hold;
    group_position_next = group_position;
    line_char_seen_next = line_char_seen;
    padding_seen_next   = padding_seen;
    decoded_count_next  = decoded_count;
    error_latched_next  = error_latched;
    emit_k              = 2'd0;
    emit_bytes          = '0;
    b64_err             = 1'b0;
    b64_value           = '0;
    pad_after           = padding_seen;
    full_group          = {sextet_hold, bd.value};
    pkt                 = '0;

    unique case (operation)
      OP_START: begin
        sextet_hold_next    = '0;
        group_position_next = '0;
        line_char_seen_next = 1'b0;
        padding_seen_next   = '0;
        decoded_count_next  = '0;
        error_latched_next  = 1'b0;
      end
      OP_CHAR: begin
        if (!error_latched) begin
          line_char_seen_next = 1'b1;
          if (base64_mode) begin
            if (padding_seen != 2'd0 && group_position == 2'd0) begin
              b64_err = 1'b1;
            end else if (character == CHAR_PAD) begin
              if (group_position < 2'd2) begin
                b64_err = 1'b1;
              end else begin
                pad_after = padding_seen + 2'd1;
              end
            end else if (!bd.ok || padding_seen != 2'd0) begin
              b64_err = 1'b1;
            end else begin
              b64_value = bd.value;
            end
            full_group = {sextet_hold, b64_value};
            if (b64_err) begin
              error_latched_next = 1'b1;
            end else if (group_position != 2'd3) begin
              padding_seen_next   = pad_after;
              sextet_hold_next    = {sextet_hold[11:0], b64_value};
              group_position_next = group_position + 2'd1;
            end else begin
              padding_seen_next   = pad_after;
              sextet_hold_next    = '0;
              group_position_next = '0;
              emit_k     = (pad_after == 2'd0) ? 2'd3 : (pad_after == 2'd1) ? 2'd2 : 2'd1;
              emit_bytes = {full_group[7:0], full_group[15:8], full_group[23:16]};
            end
          end else begin
            if (!hd.ok) begin
              error_latched_next = 1'b1;
            end else if (group_position == 2'd0) begin
              sextet_hold_next    = {14'd0, hd.value[3:0]};
              group_position_next = 2'd1;
            end else begin
              sextet_hold_next    = '0;
              group_position_next = '0;
              emit_k              = 2'd1;
              emit_bytes          = {16'd0, sextet_hold[3:0], hd.value[3:0]};
            end
          end
        end
      end
      OP_EOL: begin
        if (!error_latched && line_error) begin
          error_latched_next = 1'b1;
        end
        sextet_hold_next    = '0;
        group_position_next = '0;
        line_char_seen_next = 1'b0;
        padding_seen_next   = '0;
      end
      OP_FINISH: begin
        if (line_char_seen || group_position != 2'd0) begin
          if (!error_latched && line_error) begin
            error_latched_next = 1'b1;
          end
          sextet_hold_next    = '0;
          group_position_next = '0;
          line_char_seen_next = 1'b0;
          padding_seen_next   = '0;
        end
      end
      default: begin
      end
    endcase

    // Bytes go out while the count remains below the limit; the first that does
    // not fit latches the error.
    room    = (decoded_count >= limit) ? '0 : limit - decoded_count;
    emitted = (room >= CountWidth'(emit_k)) ? emit_k : room[1:0];
    if (emit_k != 2'd0) begin
      if (room < CountWidth'(emit_k)) begin
        error_latched_next = 1'b1;
      end
      decoded_count_next = decoded_count + CountWidth'(emitted);
      pkt.nres  = emitted;
      pkt.kind  = KIND_DATA;
      pkt.bytes = emit_bytes;
      pkt.base  = decoded_count + CountWidth'(1);
    end

    if (operation == OP_EOL || operation == OP_FINISH) begin
      pkt.nres    = 2'd1;
      pkt.kind    = (operation == OP_EOL) ? KIND_EOL : KIND_FINAL;
      pkt.base    = decoded_count;
      pkt.error   = error_latched_next;
      pkt.success = (operation == OP_FINISH) && !error_latched_next &&
                    (decoded_count != '0);
    end
  end

  assign push        = accept && (pkt.nres != 2'd0);
  assign push_packet = pkt;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= CAPACITY_RESET;
      sextet_hold    <= '0;
      group_position <= '0;
      line_char_seen <= 1'b0;
      padding_seen   <= '0;
      decoded_count  <= '0;
      error_latched  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        sextet_hold    <= sextet_hold_next;
        group_position <= group_position_next;
        line_char_seen <= line_char_seen_next;
        padding_seen   <= padding_seen_next;
        decoded_count  <= decoded_count_next;
        error_latched  <= error_latched_next;
      end
    end
  end

endmodule

[rtl/hbad_queue.sv]
// Two-entry packet queue between the front end and the output stage.
// Depends on hbad_pkg for the packet type.
module hbad_queue import hbad_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  packet_t push_packet,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output packet_t head
);

  packet_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_packet;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/hbad_back.sv]
// Output stage: walks the results of the head packet one per transfer into
// a registered output. Depends on hbad_pkg.
module hbad_back import hbad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  input  packet_t               head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [7:0]            data_byte,
  output logic [CountWidth-1:0] byte_count,
  output logic                  error,
  output logic                  success,
  output logic                  last
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;

  assign load    = !empty && (!out_valid || out_ready);
  assign is_last = (idx == head.nres - 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= head.kind;
      data_byte  <= (head.kind == KIND_DATA) ? head.bytes[idx] : 8'd0;
      byte_count <= head.base + CountWidth'(idx);
      error      <= head.error;
      success    <= head.success;
      last       <= is_last;
    end
  end

endmodule

[rtl/hex_base64_asset_decoder.sv]
// Top level of the hex / base64 asset decoder: front end, packet queue and
// output stage. Depends on hbad_pkg, hbad_front, hbad_queue and hbad_back.
//
// Usage: items (operation, character, base64_mode) arrive on the in_valid /
// in_ready channel, one transfer per item. Results (kind, data_byte,
// byte_count, error, success, last) leave on the out_valid / out_ready
// channel; last marks the final result caused by one item. Start-asset
// items and characters that finish no pair or group produce no result.
// The capacity register is written through cfg_valid / cfg_data; cfg_ready
// is always high, and writes belong between assets while the block is idle.
// An item's packet passes through the packet queue into the output register.
// An item is accepted in every cycle while the two-entry packet queue has
// room. The output stage delivers one result per cycle while out_ready is
// high, so a completed base64 group of three bytes occupies the output for
// three transfers. When the receiver stalls the output register holds, the
// queue fills and in_ready drops. Reset clears all line state, the byte
// count and the error flag, and loads capacity with 4096.
module hex_base64_asset_decoder import hbad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            operation,
  input  logic [7:0]            character,
  input  logic                  base64_mode,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CountWidth-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [7:0]            data_byte,
  output logic [CountWidth-1:0] byte_count,
  output logic                  error,
  output logic                  success,
  output logic                  last
);

  logic    queue_full;
  logic    queue_empty;
  logic    push;
  logic    pop;
  packet_t push_packet;
  packet_t head;

  assign cfg_ready = 1'b1;

  hbad_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .character   (character),
    .base64_mode (base64_mode),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .queue_full  (queue_full),
    .push        (push),
    .push_packet (push_packet)
  );

  hbad_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_packet (push_packet),
    .full        (queue_full),
    .pop         (pop),
    .empty       (queue_empty),
    .head        (head)
  );

  hbad_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (queue_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data_byte  (data_byte),
    .byte_count (byte_count),
    .error      (error),
    .success    (success),
    .last       (last)
  );

endmodule
